// ----- rtl/rgbsat_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbsat_pkg
// Shared types and constants of the RGB saturation map pipeline.
// ----------------------------------------------------------------------------
package rgbsat_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_METHOD    = 4'd0;
  localparam logic [3:0] CFG_HAS_ALPHA = 4'd1;

  // Saturation measures selected by the method register
  localparam logic [1:0] METH_DIFF = 2'd0;  // max - min
  localparam logic [1:0] METH_HSV  = 2'd1;  // 256*d / max
  localparam logic [1:0] METH_SUM  = 2'd2;  // 256*d / (r+g+b)
  localparam logic [1:0] METH_HSL  = 2'd3;  // 256*d / (max+min)

  localparam int unsigned DEN_W      = 10;  // r+g+b reaches 765
  localparam int unsigned Q_W        = 8;   // quotient bits below the clip point
  localparam int unsigned STEPS      = 2;   // quotient bits per divider stage
  localparam int unsigned DIV_STAGES = Q_W / STEPS;

  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [DEN_W-1:0] den;      // divisor
    logic [DEN_W-1:0] rem;      // partial remainder, below den unless bypassed
    logic [Q_W-1:0]   quo;      // quotient bits developed so far
    logic             use_byp;  // result does not come from the divider
    logic [7:0]       byp;      // bypass result
    logic [7:0]       alpha;    // alpha to emit
  } div_pipe_t;

endpackage

// ----- rtl/rgbsat_front.sv -----
// ----------------------------------------------------------------------------
// rgbsat_front
// Entry stage: max, min, difference and divisor of one pixel, registered.
// ----------------------------------------------------------------------------
module rgbsat_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic [7:0]             alpha,
  input  logic [1:0]             method,
  input  logic                   has_alpha,
  output logic                   stg_vld_r,
  output rgbsat_pkg::div_pipe_t  stg_r
);
  import rgbsat_pkg::*;

  logic [7:0]       mx;
  logic [7:0]       mn;
  logic [7:0]       diff;
  logic [DEN_W-1:0] den;
  div_pipe_t        stg_nxt;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    diff = mx - mn;

    unique case (method)
      METH_DIFF: den = {{(DEN_W-8){1'b0}}, mx};
      METH_HSV:  den = {{(DEN_W-8){1'b0}}, mx};
      METH_SUM:  den = {2'b00, red} + {2'b00, green} + {2'b00, blue};
      METH_HSL:  den = {2'b00, mx} + {2'b00, mn};
      default:   den = {{(DEN_W-8){1'b0}}, mx};
    endcase

    stg_nxt.den   = den;
    stg_nxt.rem   = {{(DEN_W-8){1'b0}}, diff};
    stg_nxt.quo   = '0;
    stg_nxt.alpha = has_alpha ? alpha : 8'd0;

    // Black pixel, plain difference, and a quotient of exactly 256 skip the divider
    priority if (mx == 8'd0) begin
      stg_nxt.use_byp = 1'b1;
      stg_nxt.byp     = 8'd0;
    end else if (method == METH_DIFF) begin
      stg_nxt.use_byp = 1'b1;
      stg_nxt.byp     = diff;
    end else if ({{(DEN_W-8){1'b0}}, diff} == den) begin
      stg_nxt.use_byp = 1'b1;
      stg_nxt.byp     = SAT_MAX;
    end else begin
      stg_nxt.use_byp = 1'b0;
      stg_nxt.byp     = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

endmodule

// ----- rtl/rgbsat_div_stage.sv -----
// ----------------------------------------------------------------------------
// rgbsat_div_stage
// One registered slice of the restoring divider: STEPS quotient bits.
// ----------------------------------------------------------------------------
module rgbsat_div_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  rgbsat_pkg::div_pipe_t  in_stg,
  output logic                   stg_vld_r,
  output rgbsat_pkg::div_pipe_t  stg_r
);
  import rgbsat_pkg::*;

  div_pipe_t      stg_nxt;
  logic [DEN_W:0] rem2;

  always_comb begin
    stg_nxt = in_stg;
    rem2    = '0;
    for (int i = 0; i < STEPS; i++) begin
      rem2 = {stg_nxt.rem, 1'b0};
      if (rem2 >= {1'b0, stg_nxt.den}) begin
        rem2        = rem2 - {1'b0, stg_nxt.den};
        stg_nxt.quo = {stg_nxt.quo[Q_W-2:0], 1'b1};
      end else begin
        stg_nxt.quo = {stg_nxt.quo[Q_W-2:0], 1'b0};
      end
      stg_nxt.rem = rem2[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

endmodule

// ----- rtl/rgb_saturation_map_core.sv -----
// ----------------------------------------------------------------------------
// rgb_saturation_map_core
// Grey saturation value of an RGB pixel, fully pipelined, one pixel a clock.
// ----------------------------------------------------------------------------
// A pixel is taken at every clock edge where start is high; busy is always
// low, so the block accepts one item per cycle with no gaps. For each item,
// out_valid is high for exactly one cycle with out_saturation and
// out_alpha_out, and the receiver cannot hold it off. The pipeline holds
// the entry stage (max, min, divisor), four divider stages of two quotient
// bits each, and the output register.
// Configuration (method, has_alpha) is written through cfg_valid/cfg_index/
// cfg_data, always ready; write it only while no item is in flight. Writes to
// indexes other than 0 and 1 are dropped.
// ----------------------------------------------------------------------------
module rgb_saturation_map_core (
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha_in,
  // result output
  output logic       out_valid,
  output logic [7:0] out_saturation,
  output logic [7:0] out_alpha_out,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rgbsat_pkg::*;

  logic [1:0] method_r;
  logic       has_alpha_r;

  logic       vld_chain [0:DIV_STAGES];
  div_pipe_t  stg_chain [0:DIV_STAGES];

  logic       out_valid_r;
  logic [7:0] out_sat_r;
  logic [7:0] out_alpha_r;
  logic [7:0] sat_nxt;

  // The pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r    <= METH_DIFF;
      has_alpha_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_METHOD) begin
        method_r <= cfg_data[1:0];
      end
      if (cfg_index == CFG_HAS_ALPHA) begin
        has_alpha_r <= cfg_data[0];
      end
    end
  end

  // Entry stage: classify the pixel and set up the division 256*d/den
  rgbsat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .alpha     (in_alpha_in),
    .method    (method_r),
    .has_alpha (has_alpha_r),
    .stg_vld_r (vld_chain[0]),
    .stg_r     (stg_chain[0])
  );

  // Divider slices; d < den here, so the quotient fits in Q_W bits
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rgbsat_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld_chain[s]),
      .in_stg    (stg_chain[s]),
      .stg_vld_r (vld_chain[s+1]),
      .stg_r     (stg_chain[s+1])
    );
  end

  // Pick bypass value or quotient, then hold it in the output register
  assign sat_nxt = stg_chain[DIV_STAGES].use_byp ? stg_chain[DIV_STAGES].byp
                                                 : stg_chain[DIV_STAGES].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_chain[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_sat_r   <= sat_nxt;
    out_alpha_r <= stg_chain[DIV_STAGES].alpha;
  end

  assign out_valid      = out_valid_r;
  assign out_saturation = out_sat_r;
  assign out_alpha_out  = out_alpha_r;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_saturation_map_core: drives pixels with random
// gaps, rewrites method and has_alpha between drained phases, and compares
// every saturation and alpha result against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  import rgbsat_pkg::*;

  // Expected content of one result item
  typedef struct packed {
    logic [7:0] saturation;
    logic [7:0] alpha;
  } pix_result_t;

  // Scoreboard: private copy of the two registers, the saturation predictor
  // and the queue of results still owed by the pipeline.
  class sat_scoreboard;
    pix_result_t expected_q[$];
    logic [1:0]  method_r;
    logic        alpha_on;
    int unsigned errors;
    int unsigned items_in;
    int unsigned results_out;

    function new();
      method_r    = METH_DIFF;
      alpha_on    = 1'b0;
      errors      = 0;
      items_in    = 0;
      results_out = 0;
    endfunction

    // Mirror an accepted register write; unknown indexes are dropped.
    function void set_reg(logic [3:0] idx, logic [7:0] data);
      if (idx == CFG_METHOD) begin
        method_r = data[1:0];
      end else if (idx == CFG_HAS_ALPHA) begin
        alpha_on = data[0];
      end
    endfunction

    // d for METH_DIFF, else exact floor of 256*d / divisor, clipped to 255.
    function logic [7:0] saturation_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [7:0]  mx;
      logic [7:0]  mn;
      logic [7:0]  d;
      logic [9:0]  den;
      logic [17:0] quo;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx == 8'd0) return 8'd0;
      d = mx - mn;
      case (method_r)
        METH_DIFF: return d;
        METH_HSV:  den = {2'b00, mx};
        METH_SUM:  den = {2'b00, r} + {2'b00, g} + {2'b00, b};
        default:   den = {2'b00, mx} + {2'b00, mn};
      endcase
      quo = {2'b00, d, 8'h00} / {8'h00, den};
      return (quo > 18'd255) ? SAT_MAX : quo[7:0];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      pix_result_t exp_res;
      exp_res.saturation = saturation_of(r, g, b);
      exp_res.alpha      = alpha_on ? a : 8'd0;
      expected_q.push_back(exp_res);
      items_in++;
    endfunction

    task report(string msg);
      if (errors < 50) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] sat, logic [7:0] alpha);
      pix_result_t exp_res;
      results_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no pixel pending (sat %0d alpha %0d)",
                         results_out, sat, alpha));
      end else begin
        exp_res = expected_q.pop_front();
        if (sat !== exp_res.saturation)
          report($sformatf("result %0d saturation: got %0d, want %0d",
                           results_out, sat, exp_res.saturation));
        if (alpha !== exp_res.alpha)
          report($sformatf("result %0d alpha: got %0d, want %0d",
                           results_out, alpha, exp_res.alpha));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic [7:0] in_alpha_in = 8'd0;
  logic       cfg_valid = 1'b0;
  logic [3:0] cfg_index = 4'd0;
  logic [7:0] cfg_data = 8'd0;

  logic       busy;
  logic       out_valid;
  logic [7:0] out_saturation;
  logic [7:0] out_alpha_out;
  logic       cfg_ready;

  sat_scoreboard sb = new();
  int unsigned   idle_pct = 0;   // chance in 100 that the sender skips a cycle

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_saturation_map_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha_in    (in_alpha_in),
    .out_valid      (out_valid),
    .out_saturation (out_saturation),
    .out_alpha_out  (out_alpha_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the driver's
  // nonblocking updates land. Check the result first so that the oldest
  // expectation is consumed before a newly accepted item is queued.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_saturation, out_alpha_out);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_pixel(in_red, in_green, in_blue, in_alpha_in);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each is entered and left just after a rising edge. Start and
  // cfg_valid are left high on exit so that back-to-back items need no
  // lower-and-raise in one step; callers drop them when a burst ends.
  // --------------------------------------------------------------------------

  // Present one pixel, hold it until the edge that accepts it.
  task send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                  input logic [7:0] a);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_red      <= r;
    in_green    <= g;
    in_blue     <= b;
    in_alpha_in <= a;
    forever begin
      // busy only moves at rising edges, so mid-cycle is a safe look
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  // Hold the sender off until every queued result has come back.
  task wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write one register; the caller drains the pipeline first.
  task cfg_write(input logic [3:0] idx, input logic [7:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [31:0] corner_px [0:5];   // {red, green, blue, alpha}

  initial begin
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [7:0]  base;
    int unsigned sel;
    int unsigned ph;
    int unsigned blk;
    int unsigned n;

    corner_px[0] = 32'h000000FF;  // black pixel: zero for every method
    corner_px[1] = 32'hFFFFFF00;  // white: no spread at all
    corner_px[2] = 32'hFF0000AA;  // pure red: quotient of 256 clips to 255
    corner_px[3] = 32'h00FF8055;  // green max, mixed blue
    corner_px[4] = 32'h01000001;  // smallest nonzero max, still 256 before clip
    corner_px[5] = 32'hFEFFFD80;  // near white, tiny spread

    // Hold reset low, then release it at an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the corner pixels under every method. The first pass
    // runs with the reset register values, alpha off.
    for (int m = 0; m < 4; m++) begin
      if (m != 0) begin
        wait_drained();
        cfg_write(CFG_METHOD, 8'(m));
        cfg_write(CFG_HAS_ALPHA, 8'(m & 1));
        if (m == 2) cfg_write(4'd9, 8'hFF);   // stray index: must be dropped
        @(posedge clk);
        cfg_valid <= 1'b0;
      end
      for (int k = 0; k < 6; k++)
        send_pixel(corner_px[k][31:24], corner_px[k][23:16], corner_px[k][15:8],
                   corner_px[k][7:0]);
    end

    // Random part: three idle profiles, each sweeping all four methods with
    // alpha toggled. Register data carries random junk in the unused bits.
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 38 : (ph == 1) ? 80 : 0;
      for (blk = 0; blk < 4; blk++) begin
        wait_drained();
        cfg_write(CFG_METHOD, {6'($urandom), 2'(blk)});
        cfg_write(CFG_HAS_ALPHA, {7'($urandom), 1'((blk + ph) & 1)});
        if ($urandom_range(1)) cfg_write(4'($urandom_range(15, 2)), 8'($urandom));
        @(posedge clk);
        cfg_valid <= 1'b0;
        for (n = 0; n < 100; n++) begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
          a = 8'($urandom);
          sel = $urandom_range(9);
          case (sel)
            0: begin
              r = 8'd0; g = 8'd0; b = 8'd0;            // black
            end
            1: begin
              g = r; b = r;                            // grey
            end
            2: begin
              r = {8{r[0]}}; g = {8{g[0]}}; b = {8{b[0]}};  // saturated corners
            end
            3: begin
              base = 8'($urandom_range(255, 1));       // one lone channel
              r = 8'd0; g = 8'd0; b = 8'd0;
              case ($urandom_range(2))
                0: r = base;
                1: g = base;
                default: b = base;
              endcase
            end
            4: begin
              base = 8'($urandom_range(250));          // close channels
              r = base + 8'($urandom_range(5));
              g = base + 8'($urandom_range(5));
              b = base + 8'($urandom_range(5));
            end
            default: ;
          endcase
          send_pixel(r, g, b, a);
        end
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    wait_drained();
    repeat (12) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Run covered %0d pixels and %0d results: all four methods, alpha on and off,",
             sb.items_in, sb.results_out);
    $display("corner pixels, stray register writes and three sender idle profiles.");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d results still pending", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
